>>> hdl/bpdc_pkg.sv
// bpdc_pkg: shared types, constants and codes of the button press duration classifier
// used by every module under hdl; depends on nothing else
package bpdc_pkg;

  // default sizes, handed to the top level as parameter defaults
  localparam int BUTTON_COUNT_DEF = 8;
  localparam int COUNT_WIDTH_DEF  = 16;

  // fixed field and register widths
  localparam int LEVEL_W   = 8;
  localparam int ID_W      = 3;
  localparam int TICK_W    = 16;
  localparam int EXPIRY_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // reset values of the thresholds
  localparam logic [TICK_W-1:0] SHORT_TICKS_RST   = TICK_W'(5);
  localparam logic [TICK_W-1:0] LONG_TICKS_RST    = TICK_W'(50);
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = TICK_W'(50);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2
  } press_state_e;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_LEVELS   = 3'd0,
    REG_ENABLED_MASK  = 3'd1,
    REG_SHORT_TICKS   = 3'd2,
    REG_LONG_TICKS    = 3'd3,
    REG_TIMEOUT_TICKS = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    op_e                 op;
    logic [LEVEL_W-1:0]  levels;
    logic [ID_W-1:0]     button_id;
    logic                clear_after_read;
  } in_item_t;

  typedef struct packed {
    press_state_e        press_state;
    logic [ID_W-1:0]     reported_button;
  } out_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  idle_levels;
    logic [LEVEL_W-1:0]  enabled_mask;
    logic [TICK_W-1:0]   short_ticks;
    logic [TICK_W-1:0]   long_ticks;
    logic [TICK_W-1:0]   timeout_ticks;
  } cfg_t;

  // strobes from the top level to every lane
  typedef struct packed {
    logic                tick;
    logic                rd_clear;
    logic [LEVEL_W-1:0]  levels;
    logic [ID_W-1:0]     button_id;
  } lane_ctl_t;

  // what a lane shows the merging stage
  typedef struct packed {
    press_state_e        latched;
    press_state_e        latched_tick;
  } lane_stat_t;

endpackage

>>> hdl/bpdc_lane.sv
// bpdc_lane: press counter, latch and expiry countdown of one button
// depends on bpdc_pkg
module bpdc_lane #(
  parameter int COUNT_WIDTH = bpdc_pkg::COUNT_WIDTH_DEF,
  parameter int LANE_IDX    = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bpdc_pkg::cfg_t        cfg_i,
  input  bpdc_pkg::lane_ctl_t   ctl_i,
  output bpdc_pkg::lane_stat_t  stat_o
);

  localparam int CMP_W = (COUNT_WIDTH > bpdc_pkg::TICK_W) ? COUNT_WIDTH : bpdc_pkg::TICK_W;

  logic en, lvl, idl;

  if (LANE_IDX < bpdc_pkg::LEVEL_W) begin : g_pin
    assign en  = cfg_i.enabled_mask[LANE_IDX];
    assign lvl = ctl_i.levels[LANE_IDX];
    assign idl = cfg_i.idle_levels[LANE_IDX];
  end else begin : g_nopin
    // no pin and no register bit: never scanned
    assign en  = 1'b0;
    assign lvl = 1'b0;
    assign idl = 1'b0;
  end

  logic [COUNT_WIDTH-1:0]         cnt_q, cnt_d, cnt_tick;
  bpdc_pkg::press_state_e         lat_q, lat_d, lat_tick;
  logic [bpdc_pkg::EXPIRY_W-1:0]  exp_q, exp_d, exp_tick;
  logic                           hit;

  assign hit = (32'(ctl_i.button_id) == LANE_IDX);

  // tick update: countdown first, then level evaluation
  always_comb begin
    lat_tick = lat_q;
    exp_tick = exp_q;
    cnt_tick = cnt_q;
    if (exp_q != '0) begin
      exp_tick = exp_q - bpdc_pkg::EXPIRY_W'(1);
      if (exp_tick == '0) lat_tick = bpdc_pkg::ST_IDLE;
    end
    if (lvl == idl) begin
      if (CMP_W'(cnt_q) > CMP_W'(cfg_i.short_ticks)) begin
        lat_tick = (CMP_W'(cnt_q) < CMP_W'(cfg_i.long_ticks)) ? bpdc_pkg::ST_SHORT
                                                              : bpdc_pkg::ST_LONG;
        exp_tick = cfg_i.timeout_ticks;
      end
      cnt_tick = '0;
    end else if (cnt_q != '1) begin
      cnt_tick = cnt_q + COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    lat_d = lat_q;
    exp_d = exp_q;
    cnt_d = cnt_q;
    if (ctl_i.tick && en) begin
      lat_d = lat_tick;
      exp_d = exp_tick;
      cnt_d = cnt_tick;
    end else if (ctl_i.rd_clear && hit) begin
      lat_d = bpdc_pkg::ST_IDLE;
      exp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      lat_q <= bpdc_pkg::ST_IDLE;
      exp_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      lat_q <= lat_d;
      exp_q <= exp_d;
    end
  end

  assign stat_o.latched      = lat_q;
  assign stat_o.latched_tick = en ? lat_tick : lat_q;

endmodule

>>> hdl/bpdc_merge.sv
// bpdc_merge: picks the addressed lane's state and holds results in a two-beat buffer
// depends on bpdc_pkg
module bpdc_merge #(
  parameter int BUTTON_COUNT = bpdc_pkg::BUTTON_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bpdc_pkg::in_item_t    item_i,
  input  bpdc_pkg::lane_stat_t  stat_i [BUTTON_COUNT],
  output logic                  full_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bpdc_pkg::out_item_t   out_data_o
);

  bpdc_pkg::out_item_t res;
  logic [1:0]          sel;

  // an id with no lane reports idle
  always_comb begin
    sel = 2'b00;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (32'(item_i.button_id) == i) begin
        sel = sel | ((item_i.op == bpdc_pkg::OP_TICK) ? stat_i[i].latched_tick
                                                      : stat_i[i].latched);
      end
    end
    res.press_state     = bpdc_pkg::press_state_e'(sel);
    res.reported_button = item_i.button_id;
  end

  bpdc_pkg::out_item_t e0_q, e0_d, e1_q, e1_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                pop;

  assign pop = (cnt_q != 2'd0) && !out_stall_i;

  always_comb begin
    e0_d  = e0_q;
    e1_d  = e1_q;
    cnt_d = cnt_q;
    case (cnt_q)
      2'd0: begin
        if (push_i) begin
          e0_d  = res;
          cnt_d = 2'd1;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          e0_d = res;
        end else if (push_i) begin
          e1_d  = res;
          cnt_d = 2'd2;
        end else if (pop) begin
          cnt_d = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          e0_d  = e1_q;
          cnt_d = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = e0_q;

endmodule

>>> hdl/button_press_duration_classifier.sv
// button_press_duration_classifier: top level, configuration registers, lanes and merge
// depends on bpdc_pkg, bpdc_lane and bpdc_merge
//
// One beat in, one beat out. A tick beat (op 0) advances every enabled button by one
// sample: each button has its own lane with a saturating press counter, a latched
// short/long result and an expiry countdown, and all lanes update in the same cycle.
// The result of a tick is the addressed button's state after the tick; a read beat
// (op 1) returns the current state and may clear it. A new beat can be accepted on
// every clock while in_stall_o is low; the result is registered into a two-beat
// output buffer, and in_stall_o rises only once two results are waiting, so the
// input keeps flowing while one result waits to be taken. Configuration writes are
// registered, and should only be made while idle.
module button_press_duration_classifier #(
  parameter int BUTTON_COUNT = bpdc_pkg::BUTTON_COUNT_DEF,
  parameter int COUNT_WIDTH  = bpdc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bpdc_pkg::in_item_t              in_data_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bpdc_pkg::out_item_t             out_data_o,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [bpdc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bpdc_pkg::CFG_W-1:0]      cfg_data_i
);

  // configuration registers
  bpdc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpdc_pkg::REG_IDLE_LEVELS:   cfg_d.idle_levels   = cfg_data_i[bpdc_pkg::LEVEL_W-1:0];
        bpdc_pkg::REG_ENABLED_MASK:  cfg_d.enabled_mask  = cfg_data_i[bpdc_pkg::LEVEL_W-1:0];
        bpdc_pkg::REG_SHORT_TICKS:   cfg_d.short_ticks   = cfg_data_i[bpdc_pkg::TICK_W-1:0];
        bpdc_pkg::REG_LONG_TICKS:    cfg_d.long_ticks    = cfg_data_i[bpdc_pkg::TICK_W-1:0];
        bpdc_pkg::REG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i[bpdc_pkg::TICK_W-1:0];
        default: ; // writes outside the map are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_levels   <= '0;
      cfg_q.enabled_mask  <= '0;
      cfg_q.short_ticks   <= bpdc_pkg::SHORT_TICKS_RST;
      cfg_q.long_ticks    <= bpdc_pkg::LONG_TICKS_RST;
      cfg_q.timeout_ticks <= bpdc_pkg::TIMEOUT_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // beat acceptance
  logic accept, full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // strobes shared by all lanes
  bpdc_pkg::lane_ctl_t ctl;

  assign ctl.tick      = accept && (in_data_i.op == bpdc_pkg::OP_TICK);
  assign ctl.rd_clear  = accept && (in_data_i.op == bpdc_pkg::OP_READ)
                         && in_data_i.clear_after_read;
  assign ctl.levels    = in_data_i.levels;
  assign ctl.button_id = in_data_i.button_id;

  // one lane per button
  bpdc_pkg::lane_stat_t stat [BUTTON_COUNT];

  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
    bpdc_lane #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .LANE_IDX    (g)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cfg_q),
      .ctl_i  (ctl),
      .stat_o (stat[g])
    );
  end

  // select the addressed button and buffer the result beat
  bpdc_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .item_i      (in_data_i),
    .stat_i      (stat),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hdl/bpdc_checker.sv
// bpdc_checker: port-level assertions for the classifier, bound to the top level
// depends on bpdc_pkg and button_press_duration_classifier
module bpdc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input bpdc_pkg::out_item_t             out_data_o
);

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // the input is held off only while results are waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && $past(out_stall_i))
    else $error("input stalled with no result waiting");

  // no result beat without an accepted input beat
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result beat appeared from nothing");

  // state code three never leaves the block
  a_state_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.press_state != 2'd3)
    else $error("undefined press state reported");

endmodule

bind button_press_duration_classifier bpdc_checker u_bpdc_checker (.*);
